// File: sv/pmic_pkg.sv
// Package: palette, widths and shared types for the mean IoU comparator.
`timescale 1ns / 1ps
package pmic_pkg;
    localparam int NUM_LABELS_DEF = 21;
    localparam int MAX_PIXELS_DEF = 1048576;
    localparam int PALETTE_SIZE   = 21;
    localparam int FRAC_BITS      = 16;
    localparam int MEAN_W         = 17;
    localparam int DIFF_W         = 18;

    typedef logic [7:0] chan_t;

    function automatic chan_t pal_red(input int idx);
        chan_t t [PALETTE_SIZE] = '{8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd128,
            8'd64, 8'd192, 8'd64, 8'd192, 8'd64, 8'd192, 8'd64, 8'd192,
            8'd0, 8'd128, 8'd0, 8'd128, 8'd0};
        return t[idx];
    endfunction

    function automatic chan_t pal_green(input int idx);
        chan_t t [PALETTE_SIZE] = '{8'd0, 8'd0, 8'd128, 8'd128, 8'd0, 8'd0, 8'd128, 8'd128,
            8'd0, 8'd0, 8'd128, 8'd128, 8'd0, 8'd0, 8'd128, 8'd128,
            8'd64, 8'd64, 8'd192, 8'd192, 8'd64};
        return t[idx];
    endfunction

    function automatic chan_t pal_blue(input int idx);
        chan_t t [PALETTE_SIZE] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd128,
            8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd128,
            8'd0, 8'd0, 8'd0, 8'd0, 8'd128};
        return t[idx];
    endfunction
endpackage

// File: sv/palette_mean_iou_compare.sv
// Top level: palette match, per-label counters and end-of-frame mean IoU pass.
`timescale 1ns / 1ps
// After reset the block clears its counter memories, one label a cycle, then
// takes one pixel item per cycle while counting; each counter update is a
// registered read-modify-write with forwarding between neighboring items. On an
// item with last_pixel set the block counts that pixel, waits in a drain state
// for its update to land, then runs a result pass: for each of NUM_LABELS labels
// it reads both counter memories, clears that label and runs two bit-serial
// dividers side by side, each started only for a nonzero union. The pass ends
// with a divide-by-NUM_LABELS step; no item is taken during the pass. The result
// waits in an output register until taken; pixels of the next frame are taken
// meanwhile, and the next pass holds in its last step until that register is
// free.
module palette_mean_iou_compare #(
    parameter int NUM_LABELS = pmic_pkg::NUM_LABELS_DEF,
    parameter int MAX_PIXELS = pmic_pkg::MAX_PIXELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  gt_blue,
    input  logic [7:0]  gt_green,
    input  logic [7:0]  gt_red,
    input  logic [7:0]  first_blue,
    input  logic [7:0]  first_green,
    input  logic [7:0]  first_red,
    input  logic [7:0]  second_blue,
    input  logic [7:0]  second_green,
    input  logic [7:0]  second_red,
    input  logic        last_pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [pmic_pkg::MEAN_W-1:0] mean_iou_first,
    output logic [pmic_pkg::MEAN_W-1:0] mean_iou_second,
    output logic signed [pmic_pkg::DIFF_W-1:0] iou_difference
);
    localparam int LW    = $clog2(NUM_LABELS + 1);
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W = pmic_pkg::MEAN_W + $clog2(NUM_LABELS + 1);
    localparam int NPAL  = (NUM_LABELS < pmic_pkg::PALETTE_SIZE) ? NUM_LABELS
                                                                 : pmic_pkg::PALETTE_SIZE;
    // reciprocal for divide by NUM_LABELS: floor(s*RCP >> RSH)
    localparam int RSH   = SUM_W + $clog2(NUM_LABELS + 1) + 1;
    localparam logic [RSH:0] RCP = (RSH+1)'(((64'd1 << RSH) + 64'(NUM_LABELS) - 64'd1)
                                            / 64'(NUM_LABELS));
    localparam logic [LW-1:0] NO_LBL = LW'(NUM_LABELS);

    typedef enum logic [2:0] {S_INIT, S_RUN, S_DRAIN, S_RD, S_START, S_WAIT, S_MUL,
                              S_SCALE} state_t;

    state_t state_reg;

    function automatic logic [LW-1:0] find_label(input logic [7:0] b, input logic [7:0] g,
                                                 input logic [7:0] r);
        logic [LW-1:0] res;
        res = NO_LBL;
        for (int l = NPAL - 1; l >= 0; l--)
            if (b == pmic_pkg::pal_blue(l) && g == pmic_pkg::pal_green(l)
                && r == pmic_pkg::pal_red(l))
                res = LW'(l);
        return res;
    endfunction

    logic acc;
    logic [LW-1:0] gl, l1, l2;
    logic same1, same2;

    assign in_ready = (state_reg == S_RUN);
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        gl    = find_label(gt_blue, gt_green, gt_red);
        l1    = find_label(first_blue, first_green, first_red);
        l2    = find_label(second_blue, second_green, second_red);
        same1 = first_blue == gt_blue && first_green == gt_green && first_red == gt_red;
        same2 = second_blue == gt_blue && second_green == gt_green && second_red == gt_red;
    end

    logic [LW-1:0] idx_reg;
    logic [SUM_W-1:0] sum1_reg, sum2_reg;
    logic [SUM_W+RSH:0] prod1_reg, prod2_reg;
    logic [CNT_W-1:0] i1, u1, i2, u2;
    logic d1_busy, d1_done, d2_busy, d2_done, dstart, pend1_reg, pend2_reg;
    logic [pmic_pkg::MEAN_W-1:0] q1, q2, q1_reg, q2_reg;
    logic rd_en, clr_en, scale_load;
    logic [pmic_pkg::MEAN_W-1:0] m1_reg, m2_reg;
    logic out_valid_reg;

    assign rd_en      = (state_reg == S_RD);
    assign clr_en     = (state_reg == S_START) || (state_reg == S_INIT);
    assign dstart     = (state_reg == S_START);
    assign scale_load = (state_reg == S_SCALE) && (!out_valid_reg || out_ready);

    pmic_count #(.NUM_LABELS(NUM_LABELS), .MAX_PIXELS(MAX_PIXELS), .LW(LW), .CNT_W(CNT_W))
    u_cnt1 (
        .clk(clk), .rst_n(rst_n),
        .upd_en(acc && l1 != NO_LBL), .upd_inc_i(same1), .upd_inc_u(1'b1),
        .upd_addr(l1), .gt_en(acc && gl != NO_LBL && gl != l1), .gt_addr(gl),
        .clr_en(clr_en), .clr_addr(idx_reg), .rd_en(rd_en), .rd_addr(idx_reg),
        .rd_inter(i1), .rd_union(u1)
    );

    pmic_count #(.NUM_LABELS(NUM_LABELS), .MAX_PIXELS(MAX_PIXELS), .LW(LW), .CNT_W(CNT_W))
    u_cnt2 (
        .clk(clk), .rst_n(rst_n),
        .upd_en(acc && l2 != NO_LBL), .upd_inc_i(same2), .upd_inc_u(1'b1),
        .upd_addr(l2), .gt_en(acc && gl != NO_LBL && gl != l2), .gt_addr(gl),
        .clr_en(clr_en), .clr_addr(idx_reg), .rd_en(rd_en), .rd_addr(idx_reg),
        .rd_inter(i2), .rd_union(u2)
    );

    pmic_div #(.CNT_W(CNT_W)) u_div1 (
        .clk(clk), .rst_n(rst_n), .start(dstart && u1 != '0), .num(i1), .den(u1),
        .busy(d1_busy), .done(d1_done), .quot(q1)
    );

    pmic_div #(.CNT_W(CNT_W)) u_div2 (
        .clk(clk), .rst_n(rst_n), .start(dstart && u2 != '0), .num(i2), .den(u2),
        .busy(d2_busy), .done(d2_done), .quot(q2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            pend1_reg     <= 1'b0;
            pend2_reg     <= 1'b0;
        end
        else
        begin
            if (scale_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_INIT:
                begin
                    if (idx_reg == LW'(NUM_LABELS - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                    else
                        idx_reg <= idx_reg + LW'(1);
                end
                S_RUN:
                begin
                    if (acc && last_pixel)
                    begin
                        state_reg <= S_DRAIN;
                        idx_reg   <= '0;
                        sum1_reg  <= '0;
                        sum2_reg  <= '0;
                    end
                end
                // let the last pixel's write land before the sweep reads
                S_DRAIN: state_reg <= S_RD;
                S_RD: state_reg <= S_START;
                S_START:
                begin
                    pend1_reg <= (u1 != '0);
                    pend2_reg <= (u2 != '0);
                    q1_reg    <= '0;
                    q2_reg    <= '0;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (d1_done)
                    begin
                        q1_reg    <= q1;
                        pend1_reg <= 1'b0;
                    end
                    if (d2_done)
                    begin
                        q2_reg    <= q2;
                        pend2_reg <= 1'b0;
                    end
                    if (!pend1_reg && !pend2_reg && !d1_busy && !d2_busy)
                    begin
                        sum1_reg <= sum1_reg + SUM_W'(q1_reg);
                        sum2_reg <= sum2_reg + SUM_W'(q2_reg);
                        if (idx_reg == LW'(NUM_LABELS - 1))
                            state_reg <= S_MUL;
                        else
                        begin
                            idx_reg   <= idx_reg + LW'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                S_MUL:
                begin
                    prod1_reg <= (SUM_W+RSH+1)'(sum1_reg) * (SUM_W+RSH+1)'(RCP);
                    prod2_reg <= (SUM_W+RSH+1)'(sum2_reg) * (SUM_W+RSH+1)'(RCP);
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    // hold until the output register is free
                    if (scale_load)
                    begin
                        m1_reg    <= pmic_pkg::MEAN_W'(prod1_reg >> RSH);
                        m2_reg    <= pmic_pkg::MEAN_W'(prod2_reg >> RSH);
                        state_reg <= S_RUN;
                    end
                end
                default: state_reg <= S_RUN;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign mean_iou_first  = m1_reg;
    assign mean_iou_second = m2_reg;
    assign iou_difference  = $signed({1'b0, m1_reg}) - $signed({1'b0, m2_reg});

    a_no_accept_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_RUN |-> !in_ready) else $error("item taken during result pass");
    a_result_after_scale: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_SCALE) else $error("stray result");
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mean_iou_first <= 17'd65536 && mean_iou_second <= 17'd65536)
        else $error("mean out of range");
endmodule

// File: sv/pmic_div.sv
// Restoring divider: floor((num << 16) / den), one quotient bit per cycle.
`timescale 1ns / 1ps
module pmic_div #(
    parameter int CNT_W = 21
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [CNT_W-1:0]      num,
    input  logic [CNT_W-1:0]      den,
    output logic                  busy,
    output logic                  done,
    output logic [pmic_pkg::MEAN_W-1:0] quot
);
    localparam int NW = CNT_W + pmic_pkg::FRAC_BITS;
    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0]    dvd_reg, dvd_next;
    logic [CNT_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] den_reg;
    logic [SW-1:0]    step_reg, step_next;
    logic             busy_reg, done_reg;
    logic [CNT_W:0]   trial;
    logic [CNT_W+1:0] diff;

    always_comb begin
        trial     = {rem_reg[CNT_W-1:0], dvd_reg[NW-1]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        dvd_next  = {dvd_reg[NW-2:0], 1'b0};
        rem_next  = trial;
        if (!diff[CNT_W+1])
        begin
            rem_next    = diff[CNT_W:0];
            dvd_next[0] = 1'b1;
        end
        step_next = step_reg - SW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= SW'(NW);
            end
            else if (busy_reg)
            begin
                step_reg <= step_next;
                if (step_reg == SW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num, {pmic_pkg::FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    // quotient never exceeds 1.0 since intersection <= union
    assign quot = dvd_reg[pmic_pkg::MEAN_W-1:0];
endmodule

// File: sv/pmic_count.sv
// Counter memory for one prediction: read-modify-write of intersection and union.
`timescale 1ns / 1ps
module pmic_count #(
    parameter int NUM_LABELS = pmic_pkg::NUM_LABELS_DEF,
    parameter int MAX_PIXELS = pmic_pkg::MAX_PIXELS_DEF,
    parameter int LW         = 6,
    parameter int CNT_W      = 21
) (
    input  logic             clk,
    input  logic             rst_n,
    // port A: pixel update, read on the accepting edge, written in the following cycle
    input  logic             upd_en,
    input  logic             upd_inc_i,
    input  logic             upd_inc_u,
    input  logic [LW-1:0]    upd_addr,
    // second union bump for ground-truth label
    input  logic             gt_en,
    input  logic [LW-1:0]    gt_addr,
    // clear / sweep read
    input  logic             clr_en,
    input  logic [LW-1:0]    clr_addr,
    input  logic             rd_en,
    input  logic [LW-1:0]    rd_addr,
    output logic [CNT_W-1:0] rd_inter,
    output logic [CNT_W-1:0] rd_union
);
    localparam logic [CNT_W-1:0] CMAX = CNT_W'(MAX_PIXELS);

    // intersection memory and union memory, one entry per label
    logic [CNT_W-1:0] inter_mem [NUM_LABELS];
    logic [CNT_W-1:0] uni_mem   [NUM_LABELS];
    logic [CNT_W-1:0] inter_rd_reg, upl_rd_reg, ugl_rd_reg;
    logic [LW-1:0]    ra_addr;

    // write stage
    logic             s1_pl_en_reg, s1_gl_en_reg, s1_inc_i_reg, s1_inc_u_reg;
    logic [LW-1:0]    s1_pl_reg, s1_gl_reg;
    // last write, for forwarding into the item right behind it
    logic             w_pl_en_reg, w_gl_en_reg;
    logic [LW-1:0]    w_pl_reg, w_gl_reg;
    logic [CNT_W-1:0] w_inter_reg, w_upl_reg, w_ugl_reg;

    logic [CNT_W-1:0] inter_cur, upl_cur, ugl_cur;
    logic [CNT_W-1:0] inter_next, upl_next, ugl_next;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CMAX) ? v + CNT_W'(1) : v;
    endfunction

    // sweep reads and pixel reads never share a cycle
    assign ra_addr = rd_en ? rd_addr : upd_addr;

    always_comb
    begin
        inter_cur = inter_rd_reg;
        if (w_pl_en_reg && w_pl_reg == s1_pl_reg)
            inter_cur = w_inter_reg;
        upl_cur = upl_rd_reg;
        if (w_pl_en_reg && w_pl_reg == s1_pl_reg)
            upl_cur = w_upl_reg;
        else if (w_gl_en_reg && w_gl_reg == s1_pl_reg)
            upl_cur = w_ugl_reg;
        ugl_cur = ugl_rd_reg;
        if (w_pl_en_reg && w_pl_reg == s1_gl_reg)
            ugl_cur = w_upl_reg;
        else if (w_gl_en_reg && w_gl_reg == s1_gl_reg)
            ugl_cur = w_ugl_reg;
        inter_next = s1_inc_i_reg ? sat_inc(inter_cur) : inter_cur;
        upl_next   = s1_inc_u_reg ? sat_inc(upl_cur) : upl_cur;
        ugl_next   = sat_inc(ugl_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_pl_en_reg <= 1'b0;
            s1_gl_en_reg <= 1'b0;
            w_pl_en_reg  <= 1'b0;
            w_gl_en_reg  <= 1'b0;
        end
        else
        begin
            s1_pl_en_reg <= upd_en;
            s1_gl_en_reg <= gt_en;
            w_pl_en_reg  <= s1_pl_en_reg;
            w_gl_en_reg  <= s1_gl_en_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pl_reg    <= upd_addr;
        s1_gl_reg    <= gt_addr;
        s1_inc_i_reg <= upd_inc_i;
        s1_inc_u_reg <= upd_inc_u;
        w_pl_reg     <= s1_pl_reg;
        w_gl_reg     <= s1_gl_reg;
        w_inter_reg  <= inter_next;
        w_upl_reg    <= upl_next;
        w_ugl_reg    <= ugl_next;
    end

    always_ff @(posedge clk)
    begin
        if (clr_en)
        begin
            inter_mem[clr_addr] <= '0;
            uni_mem[clr_addr]   <= '0;
        end
        else
        begin
            if (s1_pl_en_reg)
            begin
                inter_mem[s1_pl_reg] <= inter_next;
                uni_mem[s1_pl_reg]   <= upl_next;
            end
            // ground-truth label differs from the predicted one here
            if (s1_gl_en_reg)
                uni_mem[s1_gl_reg] <= ugl_next;
        end
        inter_rd_reg <= inter_mem[ra_addr];
        upl_rd_reg   <= uni_mem[ra_addr];
        ugl_rd_reg   <= uni_mem[gt_addr];
    end

    assign rd_inter = inter_rd_reg;
    assign rd_union = upl_rd_reg;
endmodule

// File: bench/testbench.sv
// Testbench for palette_mean_iou_compare: directed and random pixel frames checked against a local IoU model.
`timescale 1ns / 1ps
module testbench;
    localparam int LABELS     = pmic_pkg::NUM_LABELS_DEF;
    localparam int SAT_COUNT  = pmic_pkg::MAX_PIXELS_DEF;
    localparam int NO_LABEL   = -1;
    localparam int RANDOM_PIX = 1250;

    typedef struct packed {
        pmic_pkg::chan_t blue;
        pmic_pkg::chan_t green;
        pmic_pkg::chan_t red;
    } color_t;

    typedef struct {
        color_t truth;
        color_t first;
        color_t second;
        logic   last;
    } pixel_t;

    typedef struct {
        logic [pmic_pkg::MEAN_W-1:0]        mean_first;
        logic [pmic_pkg::MEAN_W-1:0]        mean_second;
        logic signed [pmic_pkg::DIFF_W-1:0] difference;
    } iou_result_t;

    class iou_scoreboard;
        int unsigned first_inter [LABELS];
        int unsigned first_union [LABELS];
        int unsigned second_inter[LABELS];
        int unsigned second_union[LABELS];
        iou_result_t pending_means[$];
        int          mismatches;

        function int label_of(color_t c);
            for (int i = 0; i < pmic_pkg::PALETTE_SIZE && i < LABELS; i++)
                if (c.blue == pmic_pkg::pal_blue(i) && c.green == pmic_pkg::pal_green(i)
                    && c.red == pmic_pkg::pal_red(i))
                    return i;
            return NO_LABEL;
        endfunction

        function void bump(ref int unsigned cnt);
            if (cnt < SAT_COUNT)
                cnt++;
        endfunction

        function void tally(ref int unsigned inter[LABELS], ref int unsigned uni[LABELS],
                            input int truth_lbl, input int pred_lbl, input bit same);
            if (pred_lbl != NO_LABEL)
            begin
                if (same)
                    bump(inter[pred_lbl]);
                bump(uni[pred_lbl]);
            end
            if (truth_lbl != NO_LABEL && truth_lbl != pred_lbl)
                bump(uni[truth_lbl]);
        endfunction

        function logic [pmic_pkg::MEAN_W-1:0] mean_of(ref int unsigned inter[LABELS],
                                                      ref int unsigned uni[LABELS]);
            longint unsigned sum;
            sum = 0;
            for (int i = 0; i < LABELS; i++)
                if (uni[i] != 0)
                    sum += ({32'd0, inter[i]} << pmic_pkg::FRAC_BITS) / uni[i];
            return pmic_pkg::MEAN_W'(sum / LABELS);
        endfunction

        function void note_pixel(pixel_t p);
            int          gl;
            iou_result_t r;
            gl = label_of(p.truth);
            tally(first_inter, first_union, gl, label_of(p.first), p.first == p.truth);
            tally(second_inter, second_union, gl, label_of(p.second), p.second == p.truth);
            if (p.last)
            begin
                r.mean_first  = mean_of(first_inter, first_union);
                r.mean_second = mean_of(second_inter, second_union);
                r.difference  = pmic_pkg::DIFF_W'({1'b0, r.mean_first})
                                - pmic_pkg::DIFF_W'({1'b0, r.mean_second});
                pending_means = {pending_means, r};
                for (int i = 0; i < LABELS; i++)
                begin
                    first_inter[i]  = 0;
                    first_union[i]  = 0;
                    second_inter[i] = 0;
                    second_union[i] = 0;
                end
            end
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(iou_result_t got);
            iou_result_t want;
            if (pending_means.size() == 0)
            begin
                report_mismatch("unexpected result", got.mean_first, -1);
                return;
            end
            want = pending_means.pop_front();
            if (got.mean_first !== want.mean_first)
                report_mismatch("mean_iou_first", got.mean_first, want.mean_first);
            if (got.mean_second !== want.mean_second)
                report_mismatch("mean_iou_second", got.mean_second, want.mean_second);
            if (got.difference !== want.difference)
                report_mismatch("iou_difference", got.difference, want.difference);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [7:0] gt_blue, gt_green, gt_red;
    logic [7:0] first_blue, first_green, first_red;
    logic [7:0] second_blue, second_green, second_red;
    logic last_pixel;
    logic out_valid;
    logic out_ready;
    logic [pmic_pkg::MEAN_W-1:0] mean_iou_first;
    logic [pmic_pkg::MEAN_W-1:0] mean_iou_second;
    logic signed [pmic_pkg::DIFF_W-1:0] iou_difference;

    iou_scoreboard sb;
    int burst_left;
    int stall_mode;
    int cycle_count;

    palette_mean_iou_compare uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .gt_blue(gt_blue), .gt_green(gt_green), .gt_red(gt_red),
        .first_blue(first_blue), .first_green(first_green), .first_red(first_red),
        .second_blue(second_blue), .second_green(second_green), .second_red(second_red),
        .last_pixel(last_pixel),
        .out_valid(out_valid), .out_ready(out_ready),
        .mean_iou_first(mean_iou_first), .mean_iou_second(mean_iou_second),
        .iou_difference(iou_difference)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic color_t palette_color(int idx);
        color_t c;
        c.blue  = pmic_pkg::pal_blue(idx);
        c.green = pmic_pkg::pal_green(idx);
        c.red   = pmic_pkg::pal_red(idx);
        return c;
    endfunction

    function automatic color_t any_color();
        color_t c;
        if ($urandom_range(0, 9) < 7)
            return palette_color($urandom_range(0, pmic_pkg::PALETTE_SIZE - 1));
        c = color_t'(24'($urandom));
        return c;
    endfunction

    // Hold the item until accepted, then open a gap when the burst runs out.
    task automatic send_pixel(pixel_t p);
        in_valid     <= 1'b1;
        gt_blue      <= p.truth.blue;
        gt_green     <= p.truth.green;
        gt_red       <= p.truth.red;
        first_blue   <= p.first.blue;
        first_green  <= p.first.green;
        first_red    <= p.first.red;
        second_blue  <= p.second.blue;
        second_green <= p.second.green;
        second_red   <= p.second.red;
        last_pixel   <= p.last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pixel(p);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_triple(color_t t, color_t a, color_t b, logic last);
        pixel_t p;
        p.truth  = t;
        p.first  = a;
        p.second = b;
        p.last   = last;
        send_pixel(p);
    endtask

    // Receiver stall pattern: a randomly chosen style, switched periodically.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            cycle_count <= 0;
            stall_mode  <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count % 400 == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= (cycle_count % 64) >= 40;
            endcase
        end
    end

    always @(posedge clk)
    begin
        iou_result_t r;
        if (rst_n && out_valid && out_ready)
        begin
            r.mean_first  = mean_iou_first;
            r.mean_second = mean_iou_second;
            r.difference  = iou_difference;
            sb.check_result(r);
        end
    end

    initial
    begin
        #100000000;
        $display("palette_mean_iou_compare verification failed");
        $finish;
    end

    initial
    begin
        color_t black, white;
        pixel_t p;
        int sent, frame_len;
        sb = new();
        black = '0;
        white = '1;
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        last_pixel = 1'b0;
        {gt_blue, gt_green, gt_red} = '0;
        {first_blue, first_green, first_red} = '0;
        {second_blue, second_green, second_red} = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-pixel frame, all predictions correct on the background label
        send_triple(black, black, black, 1'b1);
        // every label once: first always right, second one label off
        for (int i = 0; i < pmic_pkg::PALETTE_SIZE; i++)
            send_triple(palette_color(i), palette_color(i),
                        palette_color((i + 1) % pmic_pkg::PALETTE_SIZE),
                        i == pmic_pkg::PALETTE_SIZE - 1);
        // colors outside the palette everywhere: all unions empty
        send_triple(white, white, white, 1'b1);
        // second beats first: negative difference
        send_triple(palette_color(5), white, palette_color(5), 1'b0);
        send_triple(palette_color(5), black, palette_color(5), 1'b1);

        sent = 0;
        while (sent < RANDOM_PIX)
        begin
            frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 30);
            for (int k = 0; k < frame_len; k++)
            begin
                p.truth  = any_color();
                p.first  = ($urandom_range(0, 1) == 0) ? p.truth : any_color();
                p.second = ($urandom_range(0, 2) == 0) ? p.truth : any_color();
                p.last   = (k == frame_len - 1);
                send_pixel(p);
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (sb.pending_means.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0)
            $display("palette_mean_iou_compare verification clean");
        else
            $display("palette_mean_iou_compare verification failed");
        $finish;
    end
endmodule
